[rtl/lfga_pkg.sv]
package lfga_pkg;

  // default geometry
  localparam int unsigned NumSlotsDefault = 64;
  localparam int unsigned TimeBitsDefault = 32;

  // fixed field widths of the result beat and the register
  localparam int unsigned SlotIdxBits = 6;
  localparam int unsigned UseBits     = 16;
  localparam int unsigned CfgBits     = 7;

  // register reset value and use count ceiling
  localparam logic [CfgBits-1:0] SlotsInUseReset = 7'd64;
  localparam logic [UseBits-1:0] UseMax          = 16'hFFFF;

  typedef logic [UseBits-1:0] use_cnt_t;

  // saturating increment of a use count
  function automatic use_cnt_t use_bump(input use_cnt_t cnt);
    use_bump = (cnt == UseMax) ? cnt : cnt + use_cnt_t'(1);
  endfunction

endpackage

[rtl/lfga_in_if.sv]
interface lfga_in_if #(
  parameter int unsigned TIME_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic [TIME_BITS-1:0] start_time;
  logic [TIME_BITS-1:0] end_time;

  modport source (output valid, start_time, end_time, input ready);
  modport sink   (input valid, start_time, end_time, output ready);
endinterface

[rtl/lfga_out_if.sv]
interface lfga_out_if
  import lfga_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [SlotIdxBits-1:0] slot_index;
  logic                   served;
  logic                   no_slot;
  logic [UseBits-1:0]     slot_use_count;

  modport source (output valid, slot_index, served, no_slot, slot_use_count, input ready);
  modport sink   (input valid, slot_index, served, no_slot, slot_use_count, output ready);
endinterface

[rtl/lfga_cfg_if.sv]
interface lfga_cfg_if
  import lfga_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [CfgBits-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

[rtl/lfga_slot_array.sv]
module lfga_slot_array
  import lfga_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = NumSlotsDefault,
  parameter int unsigned TIME_BITS = TimeBitsDefault,
  parameter int unsigned IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [TIME_BITS-1:0] start_i,
  input  logic [TIME_BITS-1:0] end_i,
  input  logic                 upd_i,
  output logic                 hit_o,
  output logic [IDX_W-1:0]     pick_o,
  output logic                 pick_live_o
);

  logic [TIME_BITS-1:0] end_q [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] valid_q;
  logic [NUM_SLOTS-1:0] free;
  logic [NUM_SLOTS-1:0] onehot;

  // free test on every slot in parallel
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      free[i] = !valid_q[i] || (end_q[i] < start_i);
    end
  end

  // isolate the lowest free slot
  assign onehot = free & (~free + {{(NUM_SLOTS-1){1'b0}}, 1'b1});
  assign hit_o  = |free;
  assign pick_live_o = |(onehot & valid_q);

  // one-hot to binary
  always_comb begin
    pick_o = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (onehot[i]) begin
        pick_o = pick_o | IDX_W'(i);
      end
    end
  end

  // mark the chosen slot busy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (upd_i) begin
      valid_q <= valid_q | onehot;
    end
  end

  // store its busy-until time
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (upd_i && onehot[i]) begin
        end_q[i] <= end_i;
      end
    end
  end

endmodule

[rtl/lfga_use_store.sv]
module lfga_use_store
  import lfga_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = NumSlotsDefault,
  parameter int unsigned IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  input  logic             rd_live_i,
  input  logic             wr_en_i,
  input  logic [IDX_W-1:0] wr_addr_i,
  input  use_cnt_t         wr_data_i,
  output use_cnt_t         rd_data_o
);

  use_cnt_t mem [NUM_SLOTS];
  use_cnt_t rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read, never-used slot reads zero, same-cycle write bypassed
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (!rd_live_i) begin
        rd_data_q <= '0;
      end else if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_data_q <= wr_data_i;
      end else begin
        rd_data_q <= mem[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/lowest_free_gate_allocator_unit.sv]
// channel  | dir | beat contents
// ---------+-----+-----------------------------------------------------
// in_i     | in  | start_time, end_time (TIME_BITS each)
// cfg_i    | in  | data: slots_in_use (7 bits), always ready
// out_o    | out | slot_index, served, no_slot, slot_use_count
//
// One interval per cycle unless out_o stalls; a beat goes via input and result regs.
// The slot pick (parallel end time compare and lowest-free encode) and the
// slot state update close in the same cycle, so back-to-back intervals see each
// other; the use count is read from its memory one stage later, with bypass.
// Reset clears slot valid bits and sets slots_in_use to 64; no clearing pass.
// A stalled output holds its beat and the input register; input stalls after.
module lowest_free_gate_allocator_unit
  import lfga_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = NumSlotsDefault,
  parameter int unsigned TIME_BITS = TimeBitsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lfga_in_if.sink    in_i,
  lfga_cfg_if.sink   cfg_i,
  lfga_out_if.source out_o
);

  localparam int unsigned IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // input stage
  logic                 a_valid_q;
  logic [TIME_BITS-1:0] a_start_q;
  logic [TIME_BITS-1:0] a_end_q;

  // result stage
  logic                 b_valid_q;
  logic                 b_noslot_q;
  logic                 b_served_q;
  logic [IdxW-1:0]      b_idx_q;

  logic [CfgBits-1:0]   slots_in_use_q;

  logic                 advance;
  logic                 a_fire;
  logic                 hit;
  logic                 pick_live;
  logic [IdxW-1:0]      pick;
  logic                 served_d;
  use_cnt_t             use_old;
  use_cnt_t             use_new;
  logic                 b_wr;
  logic [IdxW+6:0]      pick_ext;
  logic [IdxW+6:0]      limit_ext;
  logic [IdxW+5:0]      idx_out_ext;

  // handshakes
  assign advance    = !b_valid_q || out_o.ready;
  assign a_fire     = a_valid_q && advance;
  assign in_i.ready = !a_valid_q || advance;
  assign cfg_i.ready = 1'b1;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_in_use_q <= SlotsInUseReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      slots_in_use_q <= cfg_i.data;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      a_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      a_start_q <= in_i.start_time;
      a_end_q   <= in_i.end_time;
    end
  end

  // slot pick and end time state
  lfga_slot_array #(
    .NUM_SLOTS (NUM_SLOTS),
    .TIME_BITS (TIME_BITS),
    .IDX_W     (IdxW)
  ) u_slots (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (a_start_q),
    .end_i       (a_end_q),
    .upd_i       (a_fire && hit),
    .hit_o       (hit),
    .pick_o      (pick),
    .pick_live_o (pick_live)
  );

  // served test against the register
  assign pick_ext  = {7'b0, pick};
  assign limit_ext = {{IdxW{1'b0}}, slots_in_use_q};
  assign served_d  = pick_ext < limit_ext;

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (advance) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_fire) begin
      b_noslot_q <= !hit;
      b_served_q <= hit && served_d;
      b_idx_q    <= hit ? pick : '0;
    end
  end

  // use counts, written back when the beat leaves
  assign use_new = use_bump(use_old);
  assign b_wr    = b_valid_q && !b_noslot_q && out_o.ready;

  lfga_use_store #(
    .NUM_SLOTS (NUM_SLOTS),
    .IDX_W     (IdxW)
  ) u_uses (
    .clk_i     (clk_i),
    .rd_en_i   (a_fire && hit),
    .rd_addr_i (pick),
    .rd_live_i (pick_live),
    .wr_en_i   (b_wr),
    .wr_addr_i (b_idx_q),
    .wr_data_i (use_new),
    .rd_data_o (use_old)
  );

  // output beat
  assign idx_out_ext          = {6'b0, b_idx_q};
  assign out_o.valid          = b_valid_q;
  assign out_o.slot_index     = idx_out_ext[SlotIdxBits-1:0];
  assign out_o.served         = b_served_q;
  assign out_o.no_slot        = b_noslot_q;
  assign out_o.slot_use_count = b_noslot_q ? '0 : use_new;

  // a no-slot beat carries no allocation
  a_noslot_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.no_slot) |-> (!out_o.served && (out_o.slot_index == '0)
      && (out_o.slot_use_count == '0)))
    else $error("no-slot beat carries allocation fields");

  // an allocation in the input stage lands as an allocated result
  a_alloc_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_fire && hit) |=> (b_valid_q && !b_noslot_q))
    else $error("allocation lost between stages");

  // a stalled result keeps its slot and the count memory is not written
  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid_q && !out_o.ready) |=> (b_valid_q && $stable(b_idx_q) && !$past(b_wr)))
    else $error("stalled result changed");

  // the input register does not advance while the result is stalled
  a_no_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && b_valid_q && !out_o.ready) |-> !in_i.ready)
    else $error("input taken over a stalled pipeline");

endmodule
